/* src/rdom_pkg.sv */
// Package for the ring deque with occupancy marks.
// Holds sizes, command codes and the request, response and internal structs.
// No dependencies.
package rdom_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_CLEAR      = 3'd3,
		CMD_STATUS     = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] data_word;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic [31:0] front_word;
		logic        front_valid;
		logic [4:0]  used_count;
		logic [4:0]  free_count;
	} rsp_t;

	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [IDX_W-1:0]      raddr;
	} mem_req_t;

	typedef struct packed {
		logic                  acc;
		logic                  fv;
		logic [CNT_W-1:0]      used;
		logic                  fwd;
		logic [DATA_WIDTH-1:0] fwd_word;
	} stat_t;

endpackage

/* src/rdom_mem.sv */
// Slot data store: one write port, one registered read port.
// Depends on rdom_pkg for sizes and the memory request struct.
module rdom_mem
	import rdom_pkg::*;
(
	input  logic                  clk,
	input  mem_req_t              mreq,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.re) begin
			rdata <= mem[mreq.raddr];
		end
	end

endmodule

/* src/rdom_ctrl.sv */
// Deque control: head/tail indices, full marks, command decode.
// Issues slot writes and the head read; depends on rdom_pkg.
module rdom_ctrl
	import rdom_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  req_t     req,
	output mem_req_t mreq,
	output stat_t    stat
);

	logic [DEPTH-1:0] full_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;

	logic [DEPTH-1:0]      nfull;
	logic [IDX_W-1:0]      nh;
	logic [IDX_W-1:0]      nt;
	logic [IDX_W-1:0]      prev_h;
	logic                  acc;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [DATA_WIDTH-1:0] word;
	logic [CNT_W-1:0]      used;

	assign word   = DATA_WIDTH'(req.data_word);
	assign prev_h = (head_q == '0) ? IDX_LAST : head_q - IDX_W'(1);

	always_comb begin
		nfull = full_q;
		nh    = head_q;
		nt    = tail_q;
		acc   = 1'b0;
		we    = 1'b0;
		waddr = tail_q;
		case (req.cmd)
			CMD_PUSH_BACK: begin
				if (!full_q[tail_q]) begin
					we            = 1'b1;
					waddr         = tail_q;
					nfull[tail_q] = 1'b1;
					nt            = (tail_q == IDX_LAST) ? '0 : tail_q + IDX_W'(1);
					acc           = 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				if (!full_q[prev_h]) begin
					we            = 1'b1;
					waddr         = prev_h;
					nfull[prev_h] = 1'b1;
					nh            = prev_h;
					acc           = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (full_q[head_q]) begin
					nfull[head_q] = 1'b0;
					nh            = (head_q == IDX_LAST) ? '0 : head_q + IDX_W'(1);
					acc           = 1'b1;
				end
			end
			CMD_CLEAR: begin
				nfull = '0;
				nh    = '0;
				nt    = '0;
				acc   = 1'b1;
			end
			CMD_STATUS: begin
				acc = 1'b1;
			end
			default: begin
				acc = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (nt < nh) begin
			used = CNT_DEPTH + CNT_W'(nt) - CNT_W'(nh);
		end else if (nt > nh) begin
			used = CNT_W'(nt) - CNT_W'(nh);
		end else begin
			used = nfull[nh] ? CNT_DEPTH : '0;
		end
	end

	assign mreq.we    = take && we;
	assign mreq.waddr = waddr;
	assign mreq.wdata = word;
	assign mreq.re    = take;
	assign mreq.raddr = nh;

	assign stat.acc      = acc;
	assign stat.fv       = nfull[nh];
	assign stat.used     = used;
	assign stat.fwd      = we && (waddr == nh);
	assign stat.fwd_word = word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			head_q <= '0;
			tail_q <= '0;
		end else if (take) begin
			full_q <= nfull;
			head_q <= nh;
			tail_q <= nt;
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		take && req.cmd == CMD_CLEAR |=> full_q == '0 && head_q == '0 && tail_q == '0)
		else $error("clear left marks or indices set");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.we |-> !full_q[mreq.waddr])
		else $error("write to an occupied slot");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take && !acc |=> $stable(full_q) && $stable(head_q) && $stable(tail_q))
		else $error("refused request changed state");

endmodule

/* src/ring_deque_occupancy_marks.sv */
// A result passes stage one, then the output register, after its request is accepted; a stall holds it.
// Throughput: one request per cycle unless stalled; each reads the head, a push also writes a slot.
// The head read uses the data store's registered port, forwarded when written in the same cycle.
// Reset: asynchronous, all full marks and both indices cleared, pipeline emptied.
// Slot data is not reset; an empty slot's word is never shown.
module ring_deque_occupancy_marks
	import rdom_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	mem_req_t              mreq;
	stat_t                 stat;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  take;
	logic                  adv;
	logic                  valid_s1;
	stat_t                 stat_s1;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	logic [DATA_WIDTH-1:0] head_word;
	logic [CNT_W-1:0]      free_cnt;

	assign adv       = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv;
	assign take      = req_valid && req_ready;

	rdom_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (req),
		.mreq   (mreq),
		.stat   (stat)
	);

	rdom_mem u_mem (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			stat_s1 <= stat;
		end
	end

	assign head_word = stat_s1.fwd ? stat_s1.fwd_word : rdata;
	assign free_cnt  = CNT_DEPTH - stat_s1.used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.accepted    <= stat_s1.acc;
			rsp_q.front_word  <= stat_s1.fv ? 32'(head_word) : 32'd0;
			rsp_q.front_valid <= stat_s1.fv;
			rsp_q.used_count  <= 5'(stat_s1.used);
			rsp_q.free_count  <= 5'(free_cnt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_empty_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.front_valid || rsp_q.front_word == 32'd0)
		else $error("front word shown for an empty head slot");

	a_counts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> 5'(rsp_q.used_count + rsp_q.free_count) == 5'(CNT_DEPTH))
		else $error("used and free counts disagree");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(stat_s1))
		else $error("stalled request lost in stage one");

endmodule

/* tb/sv/tb_ring_deque_occupancy_marks.sv */
// Self-checking bench for ring_deque_occupancy_marks: random and directed deque requests.
// The expected responses come from a cycle-free deque model kept in this file.
// Depends on rdom_pkg and the ring_deque_occupancy_marks RTL.
`timescale 1ns / 100ps

module tb_ring_deque_occupancy_marks;
	import rdom_pkg::*;

	localparam int N_ITEMS     = 450;
	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_AT     = 60;
	localparam int HOLD_CYCLES = 70;
	localparam int MAX_REPORTS = 10;

	localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'(CMD_STATUS) + 3'd1;
	localparam logic [2:0] CMD_UNKNOWN_LAST  = 3'b111;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req       = '0;
	logic rsp_ready = 1'b0;
	logic req_ready;
	logic rsp_valid;
	rsp_t rsp;

	ring_deque_occupancy_marks dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// deque model state
	logic [DATA_WIDTH-1:0] ring_word [DEPTH];
	bit                    ring_mark [DEPTH];
	logic [IDX_W-1:0]      back_idx;
	logic [IDX_W-1:0]      front_idx;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];

	int accepted_reqs = 0;
	int checked_rsps  = 0;
	int errors        = 0;
	int refused_ops   = 0;
	int full_hits     = 0;
	int clears_done   = 0;
	int stall_cycles  = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;

	function automatic rsp_t step_deque(input req_t r);
		rsp_t             res;
		logic [IDX_W-1:0] prev;
		int unsigned      occ;
		res = '0;
		case (r.cmd)
		CMD_PUSH_BACK: begin
			if (!ring_mark[back_idx]) begin
				ring_word[back_idx] = r.data_word;
				ring_mark[back_idx] = 1'b1;
				back_idx = (back_idx == IDX_LAST) ? '0 : back_idx + 1'b1;
				res.accepted = 1'b1;
			end
		end
		CMD_PUSH_FRONT: begin
			prev = (front_idx == '0) ? IDX_LAST : front_idx - 1'b1;
			if (!ring_mark[prev]) begin
				ring_word[prev] = r.data_word;
				ring_mark[prev] = 1'b1;
				front_idx = prev;
				res.accepted = 1'b1;
			end
		end
		CMD_POP_FRONT: begin
			if (ring_mark[front_idx]) begin
				ring_mark[front_idx] = 1'b0;
				front_idx = (front_idx == IDX_LAST) ? '0 : front_idx + 1'b1;
				res.accepted = 1'b1;
			end
		end
		CMD_CLEAR: begin
			for (int i = 0; i < DEPTH; i++)
				ring_mark[i] = 1'b0;
			back_idx = '0;
			front_idx = '0;
			res.accepted = 1'b1;
		end
		CMD_STATUS: begin
			res.accepted = 1'b1;
		end
		default: begin
		end
		endcase
		if (back_idx < front_idx)
			occ = DEPTH + back_idx - front_idx;
		else if (back_idx > front_idx)
			occ = back_idx - front_idx;
		else
			occ = ring_mark[back_idx] ? DEPTH : 0;
		res.front_valid = ring_mark[front_idx];
		res.front_word  = ring_mark[front_idx] ? 32'(ring_word[front_idx]) : '0;
		res.used_count  = 5'(occ);
		res.free_count  = 5'(DEPTH - occ);
		return res;
	endfunction

	function automatic int traffic_phase(input int n);
		if (n < 150)
			return 0;
		if (n < 300)
			return 1;
		return 2;
	endfunction

	function automatic int idle_pct(input int ph, input bit sender);
		case (ph)
		0: return sender ? 13 : 49;
		1: return sender ? 49 : 13;
		default: return 0;
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic void add_req(input logic [2:0] c, input logic [31:0] w);
		req_t r;
		r.cmd = c;
		r.data_word = w;
		pending_reqs.push_back(r);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!req_valid || req_ready) begin
			if (pending_reqs.size() != 0 &&
			    $urandom_range(0, 99) >= idle_pct(traffic_phase(accepted_reqs), 1'b1)) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor: predicts on request handshakes, checks response handshakes, drives rsp_ready
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (req_valid && req_ready) begin
				exp_rsp = step_deque(req);
				expected_rsps.push_back(exp_rsp);
				accepted_reqs <= accepted_reqs + 1;
				if (!exp_rsp.accepted)
					refused_ops++;
				if (exp_rsp.used_count == CNT_DEPTH)
					full_hits++;
				if (req.cmd == CMD_CLEAR)
					clears_done++;
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("ERROR: response with none outstanding: %p", rsp);
				end else begin
					exp_rsp = expected_rsps.pop_front();
					checked_rsps++;
					if (rsp.accepted !== exp_rsp.accepted ||
					    rsp.front_word !== exp_rsp.front_word ||
					    rsp.front_valid !== exp_rsp.front_valid ||
					    rsp.used_count !== exp_rsp.used_count ||
					    rsp.free_count !== exp_rsp.free_count) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("ERROR: rsp %0d acc %b/%b word %h/%h fv %b/%b used %0d/%0d free %0d/%0d (exp/act)",
								checked_rsps, exp_rsp.accepted, rsp.accepted,
								exp_rsp.front_word, rsp.front_word,
								exp_rsp.front_valid, rsp.front_valid,
								exp_rsp.used_count, rsp.used_count,
								exp_rsp.free_count, rsp.free_count);
					end
				end
			end
			// one long back-pressure stretch so the deque pipeline fills and stalls requests
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (!hold_done && accepted_reqs >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >=
					idle_pct(traffic_phase(accepted_reqs), 1'b0));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", stall_cycles);
			$display("ring_deque_occupancy_marks test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int burst;
		int n;
		for (int i = 0; i < DEPTH; i++) begin
			ring_word[i] = '0;
			ring_mark[i] = 1'b0;
		end
		back_idx = '0;
		front_idx = '0;

		// directed: empty ring, index wrap both ways, refusals, unknown codes, clear
		add_req(CMD_STATUS, '0);
		add_req(CMD_POP_FRONT, '1);
		add_req(CMD_PUSH_BACK, '0);
		add_req(CMD_PUSH_FRONT, '1);
		add_req(CMD_STATUS, 32'h5A5A_A5A5);
		add_req(CMD_POP_FRONT, '0);
		add_req(CMD_POP_FRONT, '0);
		add_req(CMD_POP_FRONT, '0);
		add_req(CMD_PUSH_FRONT, 32'h8000_0001);
		add_req(CMD_PUSH_BACK, 32'h7FFF_FFFE);
		add_req(CMD_UNKNOWN_FIRST, '1);
		add_req(CMD_UNKNOWN_FIRST + 3'd1, '0);
		add_req(CMD_UNKNOWN_LAST, 32'hDEAD_BEEF);
		add_req(CMD_CLEAR, '1);
		add_req(CMD_STATUS, '0);
		add_req(CMD_POP_FRONT, '0);
		add_req(CMD_PUSH_FRONT, 32'h0000_FFFF);
		add_req(CMD_POP_FRONT, '1);

		// random bursts: fills that can reach a full ring, drains that can hit empty, mixes, noise
		while (pending_reqs.size() < N_ITEMS) begin
			burst = $urandom_range(0, 9);
			if (burst <= 3) begin
				n = $urandom_range(4, 20);
				repeat (n)
					add_req(($urandom_range(0, 3) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
						pick_word());
			end else if (burst <= 6) begin
				n = $urandom_range(4, 20);
				repeat (n)
					add_req(($urandom_range(0, 7) == 0) ? CMD_STATUS : CMD_POP_FRONT,
						pick_word());
			end else if (burst <= 8) begin
				n = $urandom_range(4, 12);
				repeat (n)
					add_req(3'($urandom_range(CMD_PUSH_BACK, CMD_STATUS)), pick_word());
			end else begin
				case ($urandom_range(0, 2))
				0: add_req(CMD_CLEAR, pick_word());
				1: add_req(3'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST)), pick_word());
				default: add_req(CMD_STATUS, pick_word());
				endcase
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (expected_rsps.size() != 0)
			errors += expected_rsps.size();
		$display("%0d requests checked; %0d refused, %0d with the ring full, %0d clears",
			checked_rsps, refused_ops, full_hits, clears_done);
		$display("back-pressure hold of %0d cycles applied, %0d errors", HOLD_CYCLES, errors);
		if (errors == 0)
			$display("ring_deque_occupancy_marks test passed");
		else
			$display("ring_deque_occupancy_marks test failed");
		$finish;
	end

endmodule

/* ring_deque_occupancy_marks.f */
src/rdom_pkg.sv
src/rdom_mem.sv
src/rdom_ctrl.sv
src/ring_deque_occupancy_marks.sv
tb/sv/tb_ring_deque_occupancy_marks.sv
